// ===== sv/bpq_pkg.sv =====
// ----------------------------------------------------------------------------
// bpq_pkg
// Types and codes shared by the button and proximity qualifier.
// ----------------------------------------------------------------------------
package bpq_pkg;

	localparam int unsigned CNT_W   = 16;
	localparam int unsigned LEVEL_W = 12;
	localparam int unsigned IDX_W   = 3;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_BTN   = 2'd1,
		OP_LIGHT = 2'd2,
		OP_DIST  = 2'd3
	} op_t;

	typedef enum logic [IDX_W-1:0] {
		REG_SHORT_PRESS = 3'd0,
		REG_LONG_PRESS  = 3'd1,
		REG_IDLE_RESET  = 3'd2,
		REG_LIGHT_LEVEL = 3'd3,
		REG_LIGHT_DWELL = 3'd4,
		REG_DIST_LEVEL  = 3'd5,
		REG_DIST_DWELL  = 3'd6
	} reg_idx_t;

	// button verdicts
	localparam logic [1:0] BTN_NONE  = 2'd0;
	localparam logic [1:0] BTN_SHORT = 2'd1;
	localparam logic [1:0] BTN_LONG  = 2'd2;

	// light verdicts
	localparam logic [1:0] LIGHT_NONE  = 2'd0;
	localparam logic [1:0] LIGHT_BOTH  = 2'd1;
	localparam logic [1:0] LIGHT_LEFT  = 2'd2;
	localparam logic [1:0] LIGHT_RIGHT = 2'd3;

	localparam logic [1:0] VERDICT_TICK = 2'd0;

	typedef struct packed {
		logic [CNT_W-1:0]   short_press_count;
		logic [CNT_W-1:0]   long_press_count;
		logic [CNT_W-1:0]   idle_reset_ticks;
		logic [LEVEL_W-1:0] light_level;
		logic [CNT_W-1:0]   light_dwell;
		logic [LEVEL_W-1:0] distance_level;
		logic [CNT_W-1:0]   distance_dwell;
	} cfg_t;

	typedef struct packed {
		op_t                op;
		logic               button_level;
		logic [LEVEL_W-1:0] light_left;
		logic [LEVEL_W-1:0] light_right;
		logic [LEVEL_W-1:0] distance;
	} item_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

endpackage

// ===== sv/button_and_proximity_qualifier.sv =====
// ----------------------------------------------------------------------------
// button_and_proximity_qualifier
// Debounced short/long press detection plus light and distance dwell checks.
// ----------------------------------------------------------------------------
//  channel | handshake                    | payload
//  --------+------------------------------+------------------------------------
//  in      | in_valid / in_stall          | op, button_level, light_left,
//          |                              | light_right, distance
//  out     | out_valid / out_stall        | verdict
//  config  | wr_en (no wait)              | wr_index, wr_data
//
// One word per cycle sustained while the output is not stalled; each
// accepted word gives one result word: input register, then the state
// update feeds the output register in the same cycle.
// Reset clears all counters and sensor verdicts, loads register defaults.
// A stalled output register keeps the input register full; in_stall rises
// only while both the input and output registers hold a word.
module button_and_proximity_qualifier #(
	parameter int unsigned SAMPLE_PERIOD = 3
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [bpq_pkg::IDX_W-1:0]    wr_index,
	input  logic [bpq_pkg::CNT_W-1:0]    wr_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  bpq_pkg::op_t                 op,
	input  logic                         button_level,
	input  logic [bpq_pkg::LEVEL_W-1:0]  light_left,
	input  logic [bpq_pkg::LEVEL_W-1:0]  light_right,
	input  logic [bpq_pkg::LEVEL_W-1:0]  distance,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   verdict
);
	import bpq_pkg::*;

	cfg_t       cfg;
	item_t      item_s1;
	logic       valid_s1;
	logic       out_valid_q;
	logic [1:0] verdict_q;
	logic [1:0] verdict_c;
	logic       out_load, fire, in_take;

	assign out_load = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && out_load;
	assign in_stall = valid_s1 && !out_load;
	assign in_take  = in_valid && !in_stall;

	bpq_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	bpq_core #(
		.SAMPLE_PERIOD (SAMPLE_PERIOD)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.fire    (fire),
		.item    (item_s1),
		.verdict (verdict_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take || fire) begin
			valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.op           <= op;
			item_s1.button_level <= button_level;
			item_s1.light_left   <= light_left;
			item_s1.light_right  <= light_right;
			item_s1.distance     <= distance;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			verdict_q <= verdict_c;
		end
	end

	assign out_valid = out_valid_q;
	assign verdict   = verdict_q;

endmodule

// ===== sv/bpq_cfg.sv =====
// ----------------------------------------------------------------------------
// bpq_cfg
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module bpq_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [bpq_pkg::IDX_W-1:0]    wr_index,
	input  logic [bpq_pkg::CNT_W-1:0]    wr_data,
	output bpq_pkg::cfg_t                cfg
);
	import bpq_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_press_count <= CNT_W'(5);
			cfg_q.long_press_count  <= CNT_W'(300);
			cfg_q.idle_reset_ticks  <= CNT_W'(2100);
			cfg_q.light_level       <= LEVEL_W'(300);
			cfg_q.light_dwell       <= CNT_W'(300);
			cfg_q.distance_level    <= LEVEL_W'(60);
			cfg_q.distance_dwell    <= CNT_W'(300);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SHORT_PRESS: cfg_q.short_press_count <= wr_data;
				REG_LONG_PRESS:  cfg_q.long_press_count  <= wr_data;
				REG_IDLE_RESET:  cfg_q.idle_reset_ticks  <= wr_data;
				REG_LIGHT_LEVEL: cfg_q.light_level       <= wr_data[LEVEL_W-1:0];
				REG_LIGHT_DWELL: cfg_q.light_dwell       <= wr_data;
				REG_DIST_LEVEL:  cfg_q.distance_level    <= wr_data[LEVEL_W-1:0];
				REG_DIST_DWELL:  cfg_q.distance_dwell    <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/bpq_core.sv =====
// ----------------------------------------------------------------------------
// bpq_core
// Counter state and verdict logic; one word is applied per enabled cycle.
// ----------------------------------------------------------------------------
module bpq_core #(
	parameter int unsigned SAMPLE_PERIOD = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  bpq_pkg::cfg_t cfg,
	input  logic          fire,
	input  bpq_pkg::item_t item,
	output logic [1:0]    verdict
);
	import bpq_pkg::*;

	localparam int unsigned PH_W = (SAMPLE_PERIOD > 1) ? $clog2(SAMPLE_PERIOD) : 1;
	localparam logic [PH_W-1:0] PH_LAST = PH_W'(SAMPLE_PERIOD - 1);

	logic [CNT_W-1:0] tick_timer_q, press_count_q, light_count_q, distance_count_q;
	logic [1:0]       light_verdict_q;
	logic             distance_verdict_q;
	// tick_timer modulo SAMPLE_PERIOD, kept alongside the timer
	logic [PH_W-1:0]  phase_q;

	logic [CNT_W-1:0] tick_timer_d, press_count_d, light_count_d, distance_count_d;
	logic [1:0]       light_verdict_d;
	logic             distance_verdict_d;
	logic [PH_W-1:0]  phase_d;
	logic [CNT_W-1:0] tt_inc, pc_smp;
	logic             left_blk, right_blk, dist_blk;

	always_comb begin
		left_blk  = item.light_left > cfg.light_level;
		right_blk = item.light_right > cfg.light_level;
		dist_blk  = item.distance < cfg.distance_level;

		tick_timer_d       = tick_timer_q;
		press_count_d      = press_count_q;
		light_count_d      = light_count_q;
		distance_count_d   = distance_count_q;
		light_verdict_d    = light_verdict_q;
		distance_verdict_d = distance_verdict_q;
		phase_d            = phase_q;
		verdict            = VERDICT_TICK;

		pc_smp = (phase_q == '0 && item.button_level) ? sat_inc(press_count_q)
			: press_count_q;
		tt_inc = sat_inc(tick_timer_q);

		case (item.op)
			OP_TICK: begin
				press_count_d = pc_smp;
				tick_timer_d  = tt_inc;
				// phase freezes along with a saturated timer
				if (tick_timer_q != CNT_MAX)
					phase_d = (phase_q == PH_LAST) ? '0 : phase_q + 1'b1;
				if (tt_inc >= cfg.idle_reset_ticks && !item.button_level) begin
					tick_timer_d  = '0;
					press_count_d = '0;
					phase_d       = '0;
				end
				if (left_blk || right_blk) begin
					light_count_d = (light_verdict_q == LIGHT_NONE)
						? sat_inc(light_count_q) : '0;
				end else begin
					light_count_d   = '0;
					light_verdict_d = LIGHT_NONE;
				end
				if (dist_blk) begin
					distance_count_d = !distance_verdict_q
						? sat_inc(distance_count_q) : '0;
				end else begin
					distance_count_d   = '0;
					distance_verdict_d = 1'b0;
				end
			end
			OP_BTN: begin
				if (item.button_level) begin
					if (press_count_q > cfg.long_press_count) begin
						tick_timer_d  = '0;
						press_count_d = '0;
						phase_d       = '0;
						verdict       = BTN_LONG;
					end
				end else if (press_count_q > cfg.short_press_count) begin
					tick_timer_d  = '0;
					press_count_d = '0;
					phase_d       = '0;
					verdict       = BTN_SHORT;
				end
			end
			OP_LIGHT: begin
				if (light_count_q > cfg.light_dwell) begin
					// neither blocked: keep the previous verdict
					if (left_blk && right_blk)
						light_verdict_d = LIGHT_BOTH;
					else if (left_blk)
						light_verdict_d = LIGHT_LEFT;
					else if (right_blk)
						light_verdict_d = LIGHT_RIGHT;
				end else begin
					light_verdict_d = LIGHT_NONE;
				end
				verdict = light_verdict_d;
			end
			default: begin
				distance_verdict_d = distance_count_q > cfg.distance_dwell;
				verdict            = {1'b0, distance_verdict_d};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_timer_q       <= '0;
			press_count_q      <= '0;
			light_count_q      <= '0;
			distance_count_q   <= '0;
			light_verdict_q    <= LIGHT_NONE;
			distance_verdict_q <= 1'b0;
			phase_q            <= '0;
		end else if (fire) begin
			tick_timer_q       <= tick_timer_d;
			press_count_q      <= press_count_d;
			light_count_q      <= light_count_d;
			distance_count_q   <= distance_count_d;
			light_verdict_q    <= light_verdict_d;
			distance_verdict_q <= distance_verdict_d;
			phase_q            <= phase_d;
		end
	end

endmodule

// ===== sv/bpq_chk.sv =====
// ----------------------------------------------------------------------------
// bpq_chk
// Port-level checks for the button and proximity qualifier.
// ----------------------------------------------------------------------------
module bpq_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] verdict
);

	// a held result word keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(verdict))
		else $error("stalled result word changed");

	// input backs up only behind a stalled, full output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output could advance");

	// every accepted word is followed by a valid result word
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> ##2 out_valid)
		else $error("result word missing after accept");

	// output drops only after a taken word
	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(!out_stall))
		else $error("result word dropped while stalled");

endmodule

bind button_and_proximity_qualifier bpq_chk u_bpq_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.verdict   (verdict)
);

// ===== sim/qualifier_monitor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qualifier_monitor
// Watches the register port and both word channels of the qualifier, keeps
// its own copy of the counters and verdicts, and checks every result word
// against the verdict predicted for the oldest outstanding input word.
// ----------------------------------------------------------------------------
module qualifier_monitor
	import bpq_pkg::*;
#(
	parameter int unsigned SAMPLE_PERIOD = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [IDX_W-1:0]    wr_index,
	input  logic [CNT_W-1:0]    wr_data,
	input  logic                in_valid,
	input  logic                in_stall,
	input  op_t                 op,
	input  logic                button_level,
	input  logic [LEVEL_W-1:0]  light_left,
	input  logic [LEVEL_W-1:0]  light_right,
	input  logic [LEVEL_W-1:0]  distance,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [1:0]          verdict,
	output int                  mismatches,
	output int                  verdicts_open,
	output int                  verdicts_checked
);

	localparam int REPORT_LIMIT = 10;
	localparam logic DIST_CLEAR   = 1'b0;
	localparam logic DIST_BLOCKED = 1'b1;
	localparam cfg_t CFG_RESET = '{16'd5, 16'd300, 16'd2100, 12'd300, 16'd300, 12'd60, 16'd300};

	typedef struct {
		op_t        op;
		logic [1:0] verdict;
	} due_t;

	due_t verdicts_due[$];

	cfg_t             cfg;
	logic [CNT_W-1:0] tick_timer;
	logic [CNT_W-1:0] press_count;
	logic [CNT_W-1:0] light_count;
	logic [1:0]       light_v;
	logic [CNT_W-1:0] dist_count;
	logic             dist_v;

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// Advance the predicted state by one word and return its verdict.
	function automatic logic [1:0] qualify_word(input item_t w);
		logic       l_blk;
		logic       r_blk;
		logic       d_blk;
		logic [1:0] v;
		l_blk = w.light_left > cfg.light_level;
		r_blk = w.light_right > cfg.light_level;
		d_blk = w.distance < cfg.distance_level;
		v = VERDICT_TICK;
		case (w.op)
			OP_TICK: begin
				if ((tick_timer % SAMPLE_PERIOD) == 0 && w.button_level)
					press_count = bump(press_count);
				tick_timer = bump(tick_timer);
				if (tick_timer >= cfg.idle_reset_ticks && !w.button_level) begin
					tick_timer = '0;
					press_count = '0;
				end
				if (l_blk || r_blk) begin
					light_count = (light_v == LIGHT_NONE) ? bump(light_count) : '0;
				end else begin
					light_count = '0;
					light_v = LIGHT_NONE;
				end
				if (d_blk) begin
					dist_count = (dist_v == DIST_CLEAR) ? bump(dist_count) : '0;
				end else begin
					dist_count = '0;
					dist_v = DIST_CLEAR;
				end
			end
			OP_BTN: begin
				v = BTN_NONE;
				if (w.button_level) begin
					if (press_count > cfg.long_press_count) begin
						tick_timer = '0;
						press_count = '0;
						v = BTN_LONG;
					end
				end else if (press_count > cfg.short_press_count) begin
					tick_timer = '0;
					press_count = '0;
					v = BTN_SHORT;
				end
			end
			OP_LIGHT: begin
				// with nothing blocked now, a qualified verdict keeps its old value
				if (light_count > cfg.light_dwell) begin
					if (l_blk && r_blk)
						light_v = LIGHT_BOTH;
					else if (l_blk)
						light_v = LIGHT_LEFT;
					else if (r_blk)
						light_v = LIGHT_RIGHT;
				end else begin
					light_v = LIGHT_NONE;
				end
				v = light_v;
			end
			OP_DIST: begin
				dist_v = (dist_count > cfg.distance_dwell) ? DIST_BLOCKED : DIST_CLEAR;
				v = {1'b0, dist_v};
			end
			default: v = VERDICT_TICK;
		endcase
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		item_t seen;
		due_t  due;
		if (!arst_n) begin
			cfg = CFG_RESET;
			tick_timer = '0;
			press_count = '0;
			light_count = '0;
			light_v = LIGHT_NONE;
			dist_count = '0;
			dist_v = DIST_CLEAR;
			verdicts_due.delete();
			mismatches = 0;
			verdicts_checked = 0;
			verdicts_open <= 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_SHORT_PRESS: cfg.short_press_count = wr_data;
					REG_LONG_PRESS:  cfg.long_press_count = wr_data;
					REG_IDLE_RESET:  cfg.idle_reset_ticks = wr_data;
					REG_LIGHT_LEVEL: cfg.light_level = wr_data[LEVEL_W-1:0];
					REG_LIGHT_DWELL: cfg.light_dwell = wr_data;
					REG_DIST_LEVEL:  cfg.distance_level = wr_data[LEVEL_W-1:0];
					REG_DIST_DWELL:  cfg.distance_dwell = wr_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				verdicts_checked++;
				if (verdicts_due.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: verdict %0d arrived with no word outstanding",
							$realtime, verdict);
				end else begin
					due = verdicts_due.pop_front();
					if (verdict !== due.verdict) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display("%0t: %s verdict mismatch, expected %0d, got %0d",
								$realtime, due.op.name(), due.verdict, verdict);
					end
				end
			end
			if (in_valid && !in_stall) begin
				seen = '{op, button_level, light_left, light_right, distance};
				due.op = seen.op;
				due.verdict = qualify_word(seen);
				verdicts_due.push_back(due);
			end
			verdicts_open <= verdicts_due.size();
		end
	end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the button and proximity qualifier through directed and random
// tick/query streams under several register settings and idle patterns,
// including a long output hold and a blocked run against near-ceiling
// thresholds. Checking is done by qualifier_monitor; this module makes
// stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
	import bpq_pkg::*;

	localparam int unsigned SAMPLE_PERIOD = 3;
	localparam int SEGMENTS     = 6;
	localparam int SEG_WORDS    = 290;
	localparam int HOLD_CYCLES  = 300;
	localparam int SOAK_TICKS   = 40;
	localparam int QUIET_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;
	localparam cfg_t CFG_RESET = '{16'd5, 16'd300, 16'd2100, 12'd300, 16'd300, 12'd60, 16'd300};

	logic               clk;
	logic               arst_n;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_index;
	logic [CNT_W-1:0]   wr_data;
	logic               in_valid;
	logic               in_stall;
	op_t                op;
	logic               button_level;
	logic [LEVEL_W-1:0] light_left;
	logic [LEVEL_W-1:0] light_right;
	logic [LEVEL_W-1:0] distance;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         verdict;

	int mismatches;
	int verdicts_open;
	int verdicts_checked;

	int tx_pct;
	int rx_pct;
	int hold_asked  = 0;
	int hold_served = 0;
	int quiet       = 0;
	int ticks_sent  = 0;
	int queries_sent = 0;
	int settings    = 0;

	cfg_t stim_cfg;
	bit   btn_down;
	bit   left_dark;
	bit   right_dark;
	bit   near_obj;

	button_and_proximity_qualifier #(.SAMPLE_PERIOD(SAMPLE_PERIOD)) dut (.*);

	qualifier_monitor #(.SAMPLE_PERIOD(SAMPLE_PERIOD)) monitor (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// output side: random stall, or a long hold when asked
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_served != hold_asked) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_served = hold_asked;
			end
			out_stall <= ($urandom_range(99) < rx_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("Watchdog: no word moved for %0d cycles", quiet);
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic item_t mk(input op_t o, input logic b, input logic [LEVEL_W-1:0] l,
			input logic [LEVEL_W-1:0] r, input logic [LEVEL_W-1:0] d);
		item_t w;
		w.op = o;
		w.button_level = b;
		w.light_left = l;
		w.light_right = r;
		w.distance = d;
		return w;
	endfunction

	function automatic logic [LEVEL_W-1:0] pick_light(input bit dark);
		if (dark && stim_cfg.light_level < 4095)
			return LEVEL_W'($urandom_range(4095, stim_cfg.light_level + 1));
		else if (!dark)
			return LEVEL_W'($urandom_range(stim_cfg.light_level, 0));
		return LEVEL_W'($urandom_range(4095, 0));
	endfunction

	function automatic logic [LEVEL_W-1:0] pick_distance(input bit close);
		if (close && stim_cfg.distance_level > 0)
			return LEVEL_W'($urandom_range(stim_cfg.distance_level - 1, 0));
		else if (!close)
			return LEVEL_W'($urandom_range(4095, stim_cfg.distance_level));
		return LEVEL_W'($urandom_range(4095, 0));
	endfunction

	// Mostly coherent episodes: the button and each sensor stay in one state
	// for a while, with a little pure noise mixed in.
	function automatic item_t next_random_word();
		item_t       w;
		int unsigned pick;
		if ($urandom_range(99) < 3) btn_down = !btn_down;
		if ($urandom_range(99) < 4) left_dark = !left_dark;
		if ($urandom_range(99) < 4) right_dark = !right_dark;
		if ($urandom_range(99) < 4) near_obj = !near_obj;
		pick = $urandom_range(99);
		if (pick < 72)
			w.op = OP_TICK;
		else if (pick < 81)
			w.op = OP_BTN;
		else if (pick < 90)
			w.op = OP_LIGHT;
		else
			w.op = OP_DIST;
		if ($urandom_range(99) < 8) begin
			w.op = op_t'($urandom_range(3));
			w.button_level = 1'($urandom_range(1));
			w.light_left = LEVEL_W'($urandom_range(4095));
			w.light_right = LEVEL_W'($urandom_range(4095));
			w.distance = LEVEL_W'($urandom_range(4095));
		end else begin
			w.button_level = btn_down;
			w.light_left = pick_light(left_dark);
			w.light_right = pick_light(right_dark);
			w.distance = pick_distance(near_obj);
		end
		return w;
	endfunction

	function automatic cfg_t random_config();
		cfg_t c;
		c.short_press_count = CNT_W'($urandom_range(8));
		c.long_press_count = CNT_W'($urandom_range(30, 3));
		c.idle_reset_ticks = CNT_W'($urandom_range(200, 5));
		c.light_level = LEVEL_W'($urandom_range(4094, 1));
		c.light_dwell = CNT_W'($urandom_range(12));
		c.distance_level = LEVEL_W'($urandom_range(4094, 1));
		c.distance_dwell = CNT_W'($urandom_range(12));
		return c;
	endfunction

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
	endtask

	// Only called with the block idle. The spare index must change nothing.
	task automatic load_config(input cfg_t c);
		stim_cfg = c;
		settings++;
		write_reg(REG_SHORT_PRESS, c.short_press_count);
		write_reg(REG_LONG_PRESS, c.long_press_count);
		write_reg(REG_IDLE_RESET, c.idle_reset_ticks);
		write_reg(REG_LIGHT_LEVEL, {4'd0, c.light_level});
		write_reg(REG_LIGHT_DWELL, c.light_dwell);
		write_reg(REG_DIST_LEVEL, {4'd0, c.distance_level});
		write_reg(REG_DIST_DWELL, c.distance_dwell);
		write_reg(REG_SPARE, CNT_W'($urandom_range(16'hffff)));
		wr_en <= 1'b0;
	endtask

	task automatic send_word(input item_t w);
		while ($urandom_range(99) < tx_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= w.op;
		button_level <= w.button_level;
		light_left <= w.light_left;
		light_right <= w.light_right;
		distance <= w.distance;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (w.op == OP_TICK)
			ticks_sent++;
		else
			queries_sent++;
	endtask

	// Drop valid and wait for every outstanding verdict.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (verdicts_open != 0) @(posedge clk);
	endtask

	initial begin : stimulus
		cfg_t seg_cfg;
		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= '0;
		wr_data <= '0;
		in_valid <= 1'b0;
		op <= OP_TICK;
		button_level <= 1'b0;
		light_left <= '0;
		light_right <= '0;
		distance <= '0;
		stim_cfg = CFG_RESET;
		tx_pct = 29;
		rx_pct = 75;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: both/right light, blocked/clear distance, short and
		// long press, idle clear, threshold equality and reading extremes
		load_config('{16'd0, 16'd1, 16'd5, 12'd2000, 16'd1, 12'd100, 16'd1});
		repeat (3) send_word(mk(OP_TICK, 1'b1, 12'd4095, 12'd4095, 12'd0));
		send_word(mk(OP_LIGHT, 1'b1, 12'd4095, 12'd4095, 12'd0));
		send_word(mk(OP_DIST, 1'b1, 12'd4095, 12'd4095, 12'd0));
		send_word(mk(OP_BTN, 1'b1, 12'd4095, 12'd4095, 12'd0));
		repeat (2) send_word(mk(OP_TICK, 1'b1, 12'd4095, 12'd0, 12'd0));
		send_word(mk(OP_BTN, 1'b1, 12'd4095, 12'd0, 12'd0));
		send_word(mk(OP_LIGHT, 1'b0, 12'd4095, 12'd0, 12'd0));
		send_word(mk(OP_TICK, 1'b0, 12'd2000, 12'd2001, 12'd100));
		send_word(mk(OP_TICK, 1'b0, 12'd0, 12'd4095, 12'd4095));
		send_word(mk(OP_LIGHT, 1'b0, 12'd0, 12'd4095, 12'd4095));
		send_word(mk(OP_DIST, 1'b0, 12'd0, 12'd4095, 12'd4095));
		repeat (2) send_word(mk(OP_TICK, 1'b1, 12'd0, 12'd0, 12'd0));
		send_word(mk(OP_BTN, 1'b0, 12'd0, 12'd0, 12'd0));
		repeat (5) send_word(mk(OP_TICK, 1'b0, 12'd0, 12'd0, 12'd4095));
		send_word(mk(OP_BTN, 1'b0, 12'd0, 12'd0, 12'd4095));
		send_word(mk(OP_LIGHT, 1'b0, 12'd0, 12'd0, 12'd4095));
		settle();

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg / 2)
				0: begin tx_pct = 29; rx_pct = 75; end
				1: begin tx_pct = 75; rx_pct = 29; end
				default: begin tx_pct = 0; rx_pct = 0; end
			endcase
			case (seg)
				0: seg_cfg = '{16'd2, 16'd10, 16'd40, 12'd1000, 16'd5, 12'd500, 16'd5};
				1: seg_cfg = '{16'd0, 16'd0, 16'd1, 12'd0, 16'd0, 12'd4095, 16'd0};
				3: seg_cfg = '{16'hffff, 16'hffff, 16'hffff, 12'd4095, 16'hffff, 12'd0,
					16'hffff};
				5: seg_cfg = CFG_RESET;
				default: seg_cfg = random_config();
			endcase
			load_config(seg_cfg);
			for (int i = 0; i < SEG_WORDS; i++) begin
				// hold the output long enough to back up the input side
				if (i == 100 && (seg == 0 || seg == SEGMENTS - 1))
					hold_asked++;
				send_word(next_random_word());
			end
			settle();
		end

		// keep everything blocked against thresholds near the counter ceiling
		load_config('{16'd0, 16'hfffe, 16'hffff, 12'd0, 16'hfffe, 12'd4095, 16'hfffe});
		repeat (SOAK_TICKS) send_word(mk(OP_TICK, 1'b1, 12'd4095, 12'd4095, 12'd0));
		send_word(mk(OP_LIGHT, 1'b1, 12'd4095, 12'd4095, 12'd0));
		send_word(mk(OP_DIST, 1'b1, 12'd4095, 12'd4095, 12'd0));
		send_word(mk(OP_BTN, 1'b1, 12'd4095, 12'd4095, 12'd0));
		repeat (3) send_word(mk(OP_TICK, 1'b1, 12'd4095, 12'd4095, 12'd0));
		send_word(mk(OP_LIGHT, 1'b1, 12'd0, 12'd4095, 12'd0));
		send_word(mk(OP_DIST, 1'b1, 12'd0, 12'd4095, 12'd0));
		send_word(mk(OP_BTN, 1'b0, 12'd0, 12'd4095, 12'd0));
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d words (%0d ticks, %0d queries) over %0d register settings;",
			ticks_sent + queries_sent, ticks_sent, queries_sent, settings);
		$display("%0d verdicts compared, %0d output holds, %0d-tick blocked run at high limits",
			verdicts_checked, hold_served, SOAK_TICKS);
		if (mismatches == 0 && verdicts_open == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== button_and_proximity_qualifier.f =====
sv/bpq_pkg.sv
sv/bpq_cfg.sv
sv/bpq_core.sv
sv/button_and_proximity_qualifier.sv
sv/bpq_chk.sv
sim/qualifier_monitor.sv
sim/testbench.sv
